FILE: rtl/core/pfs_pkg.sv
// pfs_pkg: shared types, operation and status codes for the point fifo with search
// depends on nothing; used by the channel interfaces, the cell, the controller and the top level

package pfs_pkg;

   // queue geometry
   localparam int DEPTH_DEFAULT = 64;
   localparam int COORD_W       = 16;
   localparam int POINT_W       = 2 * COORD_W;

   // operation codes carried on func
   localparam logic [1:0] FUNC_ENQ  = 2'd0;
   localparam logic [1:0] FUNC_DEQ  = 2'd1;
   localparam logic [1:0] FUNC_SRCH = 2'd2;
   localparam logic [1:0] FUNC_NOP  = 2'd3;

   // status codes carried on status
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

   // status gathered from the ends of the cell chain
   typedef struct packed {
      logic               full;
      logic               empty;
      logic               found;
      logic [POINT_W-1:0] head_data;
   } chain_stat_type;

endpackage

FILE: rtl/core/pfs_req_if.sv
// pfs_req_if: request channel (operation and point) with valid/ready handshake
// depends on pfs_pkg for the coordinate width

interface pfs_req_if
   import pfs_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic [1:0]                func;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] y_coord;

   modport source (output valid, func, x_coord, y_coord, input ready);
   modport sink   (input valid, func, x_coord, y_coord, output ready);
endinterface

FILE: rtl/core/pfs_rsp_if.sv
// pfs_rsp_if: response channel (dequeued point, search hit, status) with valid/ready
// depends on pfs_pkg for the coordinate width

interface pfs_rsp_if
   import pfs_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic                      found;
   logic [1:0]                status;

   modport source (output valid, out_x, out_y, found, status, input ready);
   modport sink   (input valid, out_x, out_y, found, status, output ready);
endinterface

FILE: rtl/core/pfs_cell.sv
// pfs_cell: one queue slot; holds a point and its valid bit, shifts toward the head
// on dequeue and ripples a registered search hit toward the tail; uses pfs_pkg

module pfs_cell
   import pfs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic               prev_valid,
   input  logic               next_valid,
   input  logic [POINT_W-1:0] next_data,
   input  logic [POINT_W-1:0] wr_data,
   input  logic [POINT_W-1:0] key,
   input  logic               hit_in,
   output logic               valid_out,
   output logic [POINT_W-1:0] data_out,
   output logic               hit_out
);

   logic               valid_ff, valid_in;
   logic [POINT_W-1:0] data_ff, data_in;
   logic               hit_ff, hit_in_next;

   // slot update: shift on dequeue, fill the first free slot on enqueue
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.deq) begin
         valid_in = next_valid;
         data_in  = next_data;
      end else if (ctrl.enq && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         data_in  = wr_data;
      end
   end

   // search hit accumulated from the head side
   assign hit_in_next = hit_in | (valid_ff & (data_ff == key));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in_next;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
   assign hit_out   = hit_ff;

endmodule

FILE: rtl/core/pfs_ctrl.sv
// pfs_ctrl: handshake, operation decode, search wait counter and response register
// depends on pfs_pkg, pfs_req_if and pfs_rsp_if

module pfs_ctrl
   import pfs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   pfs_req_if.sink            req,
   pfs_rsp_if.source          rsp,
   input  chain_stat_type     stat,
   output cell_ctrl_type      cell_ctrl,
   output logic [POINT_W-1:0] wr_data,
   output logic [POINT_W-1:0] key
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [POINT_W-1:0]        key_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] out_x_ff, out_x_in;
   logic signed [COORD_W-1:0] out_y_ff, out_y_in;
   logic                      found_ff, found_in;
   logic [1:0]                status_ff, status_in;
   logic                      accept;
   logic                      out_free;
   logic                      search_done;

   // handshake
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign wr_data   = {req.y_coord, req.x_coord};
   assign key       = key_ff;

   // commands to the cell chain
   always_comb begin
      cell_ctrl.enq = accept && (req.func == FUNC_ENQ) && !stat.full;
      cell_ctrl.deq = accept && (req.func == FUNC_DEQ) && !stat.empty;
   end

   assign search_done = (state_ff == ST_SEARCH) && (cnt_ff == '0) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.func == FUNC_SRCH)) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (search_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // search wait counter: the hit ripples through every cell
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = CNT_W'(DEPTH);
      end else if ((state_ff == ST_SEARCH) && (cnt_ff != '0)) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      if (search_done) begin
         rsp_valid_in = 1'b1;
         out_x_in     = '0;
         out_y_in     = '0;
         found_in     = stat.found;
         status_in    = STAT_OK;
      end else if (accept && (req.func != FUNC_SRCH)) begin
         rsp_valid_in = 1'b1;
         out_x_in     = '0;
         out_y_in     = '0;
         found_in     = 1'b0;
         status_in    = STAT_OK;
         unique case (req.func)
            FUNC_ENQ: begin
               if (stat.full) status_in = STAT_FULL;
            end
            FUNC_DEQ: begin
               if (stat.empty) begin
                  status_in = STAT_EMPTY;
               end else begin
                  out_x_in = $signed(stat.head_data[COORD_W-1:0]);
                  out_y_in = $signed(stat.head_data[POINT_W-1:COORD_W]);
               end
            end
            FUNC_SRCH: status_in = STAT_OK;
            FUNC_NOP:  status_in = STAT_OK;
            default:   status_in = STAT_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      if (accept) key_ff <= wr_data;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.out_x  = out_x_ff;
   assign rsp.out_y  = out_y_ff;
   assign rsp.found  = found_ff;
   assign rsp.status = status_ff;

endmodule

FILE: rtl/core/point_fifo_with_search.sv
// point_fifo_with_search: fifo of points built as a chain of DEPTH cells, oldest at cell 0
// enqueue, dequeue and no-op codes: result registered in the cycle after the request beat,
//   one beat per cycle while the response side keeps up
// search: result registered once the wait counter has run down, the hit rippling one cell a cycle;
//   no new request is taken meanwhile
// synchronous reset empties the queue (cell valid bits) and drops any pending response

module point_fifo_with_search
   import pfs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   pfs_req_if.sink   req,
   pfs_rsp_if.source rsp
);

   cell_ctrl_type      cell_ctrl;
   chain_stat_type     stat;
   logic [POINT_W-1:0] wr_data;
   logic [POINT_W-1:0] key;
   logic               valid_q [DEPTH];
   logic [POINT_W-1:0] data_q  [DEPTH];
   logic               hit_q   [DEPTH];

   // controller
   pfs_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .stat      (stat),
      .cell_ctrl (cell_ctrl),
      .wr_data   (wr_data),
      .key       (key)
   );

   // cell chain, cell 0 holds the oldest point
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               prev_valid;
      logic               next_valid;
      logic [POINT_W-1:0] next_data;
      logic               hit_in;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
         assign hit_in     = 1'b0;
      end else begin : g_mid
         assign prev_valid = valid_q[i-1];
         assign hit_in     = hit_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_valid = 1'b0;
         assign next_data  = '0;
      end else begin : g_inner
         assign next_valid = valid_q[i+1];
         assign next_data  = data_q[i+1];
      end

      pfs_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_data  (next_data),
         .wr_data    (wr_data),
         .key        (key),
         .hit_in     (hit_in),
         .valid_out  (valid_q[i]),
         .data_out   (data_q[i]),
         .hit_out    (hit_q[i])
      );
   end

   // status from the chain ends
   always_comb begin
      stat.full      = valid_q[DEPTH-1];
      stat.empty     = !valid_q[0];
      stat.found     = hit_q[DEPTH-1];
      stat.head_data = data_q[0];
   end

endmodule

FILE: tb/sv/point_fifo_with_search_tb.sv
// point_fifo_with_search_tb: self-checking bench for the point fifo with membership search
// depends on pfs_pkg, pfs_req_if, pfs_rsp_if and point_fifo_with_search from rtl/core
// a shadow ring predicts every response beat, and a monitor process checks them in order

`timescale 1ns / 100ps

module point_fifo_with_search_tb;
   import pfs_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
   localparam int HEAD_W      = $clog2(QUEUE_DEPTH);
   localparam int TIMEOUT_NS  = 50_000_000;

   // one expected response beat
   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic                      found;
      logic [1:0]                status;
   } point_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pfs_req_if req_chan ();
   pfs_rsp_if rsp_chan ();

   point_fifo_with_search #(
      .DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_chan.sink),
      .rsp  (rsp_chan.source)
   );

   // shadow copy of the queue
   logic [POINT_W-1:0] point_ring [QUEUE_DEPTH];
   logic [HEAD_W-1:0]  ring_head  = '0;
   logic [HEAD_W:0]    ring_count = '0;

   point_result_type expected_results [$];
   int               fail_count      = 0;
   int               req_idle_pct    = 0;
   int               rsp_idle_pct    = 0;
   int               rsp_hold_cycles = 0;

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one operation to the shadow queue and return the response it causes
   function automatic point_result_type apply_point_op(input logic [1:0] func,
                                                       input logic signed [COORD_W-1:0] x,
                                                       input logic signed [COORD_W-1:0] y);
      point_result_type   res;
      logic [POINT_W-1:0] pt_word;
      res     = '0;
      pt_word = {y, x};
      case (func)
         FUNC_ENQ: begin
            if (ring_count >= QUEUE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               point_ring[(int'(ring_head) + int'(ring_count)) % QUEUE_DEPTH] = pt_word;
               ring_count = ring_count + 1'b1;
            end
         end
         FUNC_DEQ: begin
            if (ring_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.out_x  = point_ring[ring_head][COORD_W-1:0];
               res.out_y  = point_ring[ring_head][POINT_W-1:COORD_W];
               ring_head  = HEAD_W'((int'(ring_head) + 1) % QUEUE_DEPTH);
               ring_count = ring_count - 1'b1;
            end
         end
         FUNC_SRCH: begin
            for (int i = 0; i < int'(ring_count); i++) begin
               if (point_ring[(int'(ring_head) + i) % QUEUE_DEPTH] == pt_word) begin
                  res.found = 1'b1;
               end
            end
         end
         default: begin
            // no-op code: nothing changes, all fields zero
         end
      endcase
      return res;
   endfunction

   // coordinate corner values
   function automatic logic signed [COORD_W-1:0] coord_extreme();
      case ($urandom_range(4))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return -16'sd1;
         3:       return 16'sd1;
         default: return 16'sd0;
      endcase
   endfunction

   // choose a point: a queued one, a small one, a corner one or a wide random one
   task automatic pick_point(input bit from_queue,
                             output logic signed [COORD_W-1:0] x,
                             output logic signed [COORD_W-1:0] y);
      int                 sel;
      logic [POINT_W-1:0] w;
      sel = $urandom_range(99);
      if (from_queue && ring_count != 0) begin
         w = point_ring[(int'(ring_head) + $urandom_range(int'(ring_count) - 1)) % QUEUE_DEPTH];
         x = w[COORD_W-1:0];
         y = w[POINT_W-1:COORD_W];
      end else if (sel < 25) begin
         x = COORD_W'(int'($urandom_range(6)) - 3);
         y = COORD_W'(int'($urandom_range(6)) - 3);
      end else if (sel < 40) begin
         x = coord_extreme();
         y = coord_extreme();
      end else begin
         x = COORD_W'($urandom);
         y = COORD_W'($urandom);
      end
   endtask

   // send one request beat, with random idle cycles ahead of it
   task automatic send_point_op(input logic [1:0] func,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid   <= 1'b0;
         req_chan.func    <= 2'($urandom);
         req_chan.x_coord <= COORD_W'($urandom);
         req_chan.y_coord <= COORD_W'($urandom);
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.func    <= func;
      req_chan.x_coord <= x;
      req_chan.y_coord <= y;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_results.push_back(apply_point_op(func, x, y));
   endtask

   // stop offering and wait for every outstanding response
   task automatic wait_results_drained();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   // response monitor and ready driver
   initial begin
      point_result_type want;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("response beat with nothing expected: out_x %h out_y %h found %b status %h",
                      rsp_chan.out_x, rsp_chan.out_y, rsp_chan.found, rsp_chan.status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("out_x", want.out_x, rsp_chan.out_x);
               check_field("out_y", want.out_y, rsp_chan.out_y);
               check_field("found", COORD_W'(want.found), COORD_W'(rsp_chan.found));
               check_field("status", COORD_W'(want.status), COORD_W'(rsp_chan.status));
            end
         end
         // long hold-off first, otherwise random stalls
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // corner points, every operation and the empty and no-op cases
   task automatic test_directed_ops();
      send_point_op(FUNC_SRCH, 16'sd5, 16'sd5);
      send_point_op(FUNC_DEQ, 16'sd7, -16'sd7);
      send_point_op(FUNC_NOP, -16'sd1, -16'sd1);
      send_point_op(FUNC_ENQ, 16'sh8000, 16'sh7fff);
      send_point_op(FUNC_ENQ, 16'sh7fff, 16'sh8000);
      send_point_op(FUNC_ENQ, 16'sd0, 16'sd0);
      send_point_op(FUNC_ENQ, -16'sd1, -16'sd1);
      send_point_op(FUNC_ENQ, 16'sd1, -16'sd1);
      send_point_op(FUNC_SRCH, 16'sh8000, 16'sh7fff);
      // x of one entry with y of another must miss
      send_point_op(FUNC_SRCH, 16'sh7fff, 16'sh7fff);
      send_point_op(FUNC_SRCH, 16'sd1, -16'sd1);
      send_point_op(FUNC_SRCH, -16'sd1, 16'sd1);
      send_point_op(FUNC_SRCH, 16'sd0, 16'sd0);
      send_point_op(FUNC_NOP, 16'sh7fff, 16'sh8000);
      repeat (5) send_point_op(FUNC_DEQ, 16'sd0, 16'sd0);
      send_point_op(FUNC_DEQ, 16'sh7fff, 16'sh7fff);
      send_point_op(FUNC_SRCH, 16'sd0, 16'sd0);
      send_point_op(FUNC_NOP, 16'sh8000, 16'sh8000);
      wait_results_drained();
   endtask

   // fill to the last entry, overflow, search at both ends, drain past empty
   task automatic test_full_queue();
      logic signed [COORD_W-1:0] x, y;
      logic signed [COORD_W-1:0] last_x, last_y;
      for (int n = 0; n < QUEUE_DEPTH; n++) begin
         pick_point(1'b0, x, y);
         send_point_op(FUNC_ENQ, x, y);
      end
      last_x = x;
      last_y = y;
      pick_point(1'b0, x, y);
      send_point_op(FUNC_ENQ, x, y);
      send_point_op(FUNC_SRCH, x, y);
      send_point_op(FUNC_SRCH, last_x, last_y);
      send_point_op(FUNC_SRCH, point_ring[ring_head][COORD_W-1:0],
                    point_ring[ring_head][POINT_W-1:COORD_W]);
      send_point_op(FUNC_NOP, x, y);
      send_point_op(FUNC_DEQ, x, y);
      send_point_op(FUNC_ENQ, 16'sh7fff, 16'sh7fff);
      send_point_op(FUNC_ENQ, 16'sh8000, 16'sh8000);
      send_point_op(FUNC_SRCH, 16'sh7fff, 16'sh7fff);
      repeat (QUEUE_DEPTH + 1) send_point_op(FUNC_DEQ, x, y);
      wait_results_drained();
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      logic signed [COORD_W-1:0] x, y;
      req_idle_pct    = 0;
      rsp_idle_pct    = 0;
      rsp_hold_cycles = 300;
      for (int n = 0; n < 40; n++) begin
         pick_point(n[0], x, y);
         send_point_op((n % 5 == 4) ? FUNC_SRCH : (n % 3 == 2) ? FUNC_DEQ : FUNC_ENQ, x, y);
      end
      wait_results_drained();
   endtask

   // random traffic in blocks that lean toward filling, draining or balance
   task automatic test_random_traffic(input int count, input int req_pct, input int rsp_pct);
      logic signed [COORD_W-1:0] x, y;
      logic [POINT_W-1:0]        w;
      logic [1:0]                op;
      int                        mode, roll, enq_pct;
      int                        flip_bit;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      mode         = 2;
      for (int n = 0; n < count; n++) begin
         if (n % 96 == 0) mode = $urandom_range(2);
         enq_pct = (mode == 0) ? 60 : (mode == 1) ? 10 : 35;
         roll    = $urandom_range(99);
         if (roll < enq_pct)   op = FUNC_ENQ;
         else if (roll < 70)   op = FUNC_DEQ;
         else if (roll < 95)   op = FUNC_SRCH;
         else                  op = FUNC_NOP;
         if (op == FUNC_SRCH) begin
            roll = $urandom_range(99);
            pick_point(roll < 65, x, y);
            // near miss: a queued point with one bit changed
            if (roll >= 50 && roll < 65) begin
               w           = {y, x};
               flip_bit    = $urandom_range(POINT_W - 1);
               w[flip_bit] = ~w[flip_bit];
               {y, x}      = w;
            end
         end else begin
            pick_point(op == FUNC_ENQ && $urandom_range(99) < 15, x, y);
         end
         send_point_op(op, x, y);
      end
      wait_results_drained();
   endtask

   // main sequence
   initial begin
      req_chan.valid   = 1'b0;
      req_chan.func    = FUNC_NOP;
      req_chan.x_coord = '0;
      req_chan.y_coord = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 30;
      rsp_idle_pct = 88;
      test_directed_ops();
      test_full_queue();
      test_backpressure();
      test_random_traffic(385, 30, 88);
      test_random_traffic(385, 88, 30);
      test_random_traffic(385, 0, 0);

      rsp_idle_pct = 0;
      wait_results_drained();
      repeat (QUEUE_DEPTH + 8) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("point_fifo_with_search regression: pass");
      end else begin
         $display("point_fifo_with_search regression: fail");
      end
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("point_fifo_with_search regression: fail");
      $finish;
   end

endmodule
